@@ sv/ckb_pkg.sv @@
// Shared types and constants for the colour-key sprite blitter.
// Holds register codes, field widths and the configuration bundle.
// No dependencies.
package ckb_pkg;

    // Field widths fixed by the interface
    localparam int TEXEL_W   = 32;
    localparam int ADDR_W    = 17;
    localparam int DEST_W    = 13;
    localparam int SIZE_W    = 12;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [TEXEL_W-1:0] TINT_RESET = '1;

    // Register index, taken from paddr word offset
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEST_X   = 3'd0,
        REG_DEST_Y   = 3'd1,
        REG_SPRITE_W = 3'd2,
        REG_SPRITE_H = 3'd3,
        REG_TINT     = 3'd4
    } reg_idx_t;

    // Configuration held by the register block
    typedef struct packed {
        logic [DEST_W-1:0]  dest_x;
        logic [DEST_W-1:0]  dest_y;
        logic [SIZE_W-1:0]  sprite_w;
        logic [SIZE_W-1:0]  sprite_h;
        logic [TEXEL_W-1:0] tint;
        logic               restart;
    } cfg_t;

endpackage

@@ sv/color_key_sprite_blitter.sv @@
// Colour-key sprite blitter top level: rectangle clipping, texel walk, output register.
// Depends on ckb_pkg and ckb_regs.
//
// Takes one texel per clock while the output is not stalled and returns its frame
// write in the cycle after the request is accepted, held in an output register;
// the next texel is taken only when that register is free or being drained. The
// single column/row counter pair and the row-times-width multiply sit between
// the texel input and the result register. The clipped rectangle is worked out
// from the configuration registers; when it is empty, texels are accepted and
// give no result. A write of any geometry register restarts the walk at the top-left corner.
module color_key_sprite_blitter #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ckb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ckb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ckb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         texel_valid,
    output logic                         texel_ready,
    input  logic [ckb_pkg::TEXEL_W-1:0]  texel,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ckb_pkg::ADDR_W-1:0]   frame_address,
    output logic [ckb_pkg::TEXEL_W-1:0]  pixel,
    output logic                         write_enable,
    output logic                         last
);

    localparam int XW    = $clog2(FRAME_WIDTH + 1);
    localparam int YW    = $clog2(FRAME_HEIGHT + 1);
    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam int GW    = ckb_pkg::DEST_W + 1;
    localparam int MUL_W = YW + 1 + XW;
    localparam int SUM_W = (MUL_W + 1 > ckb_pkg::ADDR_W) ? MUL_W + 1 : ckb_pkg::ADDR_W;

    ckb_pkg::cfg_t cfg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ckb_pkg::ADDR_W-1:0]  frame_address_reg;
    logic [ckb_pkg::TEXEL_W-1:0] pixel_reg;
    logic                        write_enable_reg;
    logic                        last_reg;

    logic [GW-1:0] dx_ext, dy_ext, x1_sum, y1_sum, x1_cap, y1_cap;
    logic [XW-1:0] x0, cw;
    logic [YW-1:0] y0, ch;
    logic          empty, stale, accept, col_wrap, row_wrap, is_last;
    logic [COL_W-1:0] col_use;
    logic [ROW_W-1:0] row_use;
    logic [SUM_W-1:0] xs, ys, addr_sum;

    ckb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Clamp the origin into the frame and cap the far edge
    always_comb
    begin
        dx_ext = {cfg.dest_x[ckb_pkg::DEST_W-1], cfg.dest_x};
        dy_ext = {cfg.dest_y[ckb_pkg::DEST_W-1], cfg.dest_y};

        if (dx_ext[GW-1])
            x0 = '0;
        else if (dx_ext > GW'(FRAME_WIDTH))
            x0 = XW'(FRAME_WIDTH);
        else
            x0 = XW'(dx_ext);

        if (dy_ext[GW-1])
            y0 = '0;
        else if (dy_ext > GW'(FRAME_HEIGHT))
            y0 = YW'(FRAME_HEIGHT);
        else
            y0 = YW'(dy_ext);

        x1_sum = GW'(x0) + GW'(cfg.sprite_w);
        y1_sum = GW'(y0) + GW'(cfg.sprite_h);
        x1_cap = (x1_sum > GW'(FRAME_WIDTH))  ? GW'(FRAME_WIDTH)  : x1_sum;
        y1_cap = (y1_sum > GW'(FRAME_HEIGHT)) ? GW'(FRAME_HEIGHT) : y1_sum;
        cw     = XW'(x1_cap - GW'(x0));
        ch     = YW'(y1_cap - GW'(y0));
        empty  = (cw == '0) || (ch == '0);
    end

    // Restart from the corner if the counters fall outside the rectangle
    always_comb
    begin
        stale    = (XW'(col_reg) >= cw) || (YW'(row_reg) >= ch);
        col_use  = stale ? '0 : col_reg;
        row_use  = stale ? '0 : row_reg;
        col_wrap = !((XW'(col_use) + XW'(1)) < cw);
        row_wrap = !((YW'(row_use) + YW'(1)) < ch);
        is_last  = (XW'(col_use) == cw - XW'(1)) && (YW'(row_use) == ch - YW'(1));

        xs       = SUM_W'(x0) + SUM_W'(col_use);
        ys       = SUM_W'(y0) + SUM_W'(row_use);
        addr_sum = xs + ys * SUM_W'(FRAME_WIDTH);
    end

    // Take a texel whenever the output register is free or being drained
    assign texel_ready = !out_valid_reg || out_ready;
    assign accept      = texel_valid && texel_ready;

    // Advance the walk, wrapping columns into rows and rows to the corner
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && !empty)
        begin
            if (!col_wrap)
            begin
                col_next = col_use + COL_W'(1);
                row_next = row_use;
            end
            else
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_use + ROW_W'(1);
            end
        end
    end

    // Hold a result until taken; a new one replaces it in the same cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = !empty;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (accept && !empty)
        begin
            frame_address_reg <= addr_sum[ckb_pkg::ADDR_W-1:0];
            pixel_reg         <= texel & cfg.tint;
            write_enable_reg  <= (texel != '0);
            last_reg          <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_address = frame_address_reg;
    assign pixel         = pixel_reg;
    assign write_enable  = write_enable_reg;
    assign last          = last_reg;

endmodule

@@ sv/ckb_regs.sv @@
// APB-style configuration registers for the colour-key sprite blitter.
// Depends on ckb_pkg for register codes and the configuration bundle.
module ckb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ckb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ckb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ckb_pkg::PDATA_W-1:0]  prdata,
    output ckb_pkg::cfg_t                cfg
);

    logic [ckb_pkg::DEST_W-1:0]  dest_x_reg;
    logic [ckb_pkg::DEST_W-1:0]  dest_y_reg;
    logic [ckb_pkg::SIZE_W-1:0]  sprite_w_reg;
    logic [ckb_pkg::SIZE_W-1:0]  sprite_h_reg;
    logic [ckb_pkg::TEXEL_W-1:0] tint_reg;
    logic                        wr_en;
    ckb_pkg::reg_idx_t           idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = ckb_pkg::reg_idx_t'(paddr[ckb_pkg::PADDR_W-1:2]);

    // Write the addressed register; unknown indexes drop the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg   <= '0;
            dest_y_reg   <= '0;
            sprite_w_reg <= '0;
            sprite_h_reg <= '0;
            tint_reg     <= ckb_pkg::TINT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                ckb_pkg::REG_DEST_X:   dest_x_reg   <= pwdata[ckb_pkg::DEST_W-1:0];
                ckb_pkg::REG_DEST_Y:   dest_y_reg   <= pwdata[ckb_pkg::DEST_W-1:0];
                ckb_pkg::REG_SPRITE_W: sprite_w_reg <= pwdata[ckb_pkg::SIZE_W-1:0];
                ckb_pkg::REG_SPRITE_H: sprite_h_reg <= pwdata[ckb_pkg::SIZE_W-1:0];
                ckb_pkg::REG_TINT:     tint_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            ckb_pkg::REG_DEST_X:   prdata = ckb_pkg::PDATA_W'(dest_x_reg);
            ckb_pkg::REG_DEST_Y:   prdata = ckb_pkg::PDATA_W'(dest_y_reg);
            ckb_pkg::REG_SPRITE_W: prdata = ckb_pkg::PDATA_W'(sprite_w_reg);
            ckb_pkg::REG_SPRITE_H: prdata = ckb_pkg::PDATA_W'(sprite_h_reg);
            ckb_pkg::REG_TINT:     prdata = tint_reg;
            default:               prdata = '0;
        endcase
    end

    // Geometry writes restart the walk; tint writes do not
    always_comb
    begin
        cfg.dest_x   = dest_x_reg;
        cfg.dest_y   = dest_y_reg;
        cfg.sprite_w = sprite_w_reg;
        cfg.sprite_h = sprite_h_reg;
        cfg.tint     = tint_reg;
        cfg.restart  = wr_en && (idx == ckb_pkg::REG_DEST_X || idx == ckb_pkg::REG_DEST_Y
                                 || idx == ckb_pkg::REG_SPRITE_W
                                 || idx == ckb_pkg::REG_SPRITE_H);
    end

endmodule

@@ sv/ckb_checker.sv @@
// Port-level checks for the colour-key sprite blitter, bound to the top level.
// Depends on ckb_pkg for port widths.
module ckb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         texel_valid,
    input logic                         texel_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ckb_pkg::ADDR_W-1:0]   frame_address,
    input logic [ckb_pkg::TEXEL_W-1:0]  pixel,
    input logic                         write_enable,
    input logic                         last
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_address)
            && $stable(pixel) && $stable(write_enable) && $stable(last))
        else $error("result changed while stalled");

    // No new request is taken while a result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !texel_ready)
        else $error("input taken over a stalled result");

    // A transparent texel always masks to zero
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> pixel == '0)
        else $error("transparent texel gave a nonzero pixel");

    // An idle output stays idle unless a texel is accepted
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(texel_valid && texel_ready) |=> !out_valid)
        else $error("result without a request");

endmodule

bind color_key_sprite_blitter ckb_checker u_ckb_checker (.*);

@@ sim/color_key_sprite_blitter_tb.sv @@
// Self-checking testbench for the colour-key sprite blitter: directed table, then random
// geometry phases with random idling on both channels, checked against a local predictor.
// Depends on ckb_pkg and color_key_sprite_blitter.
module color_key_sprite_blitter_tb;

    localparam int FRAME_WIDTH    = 320;
    localparam int FRAME_HEIGHT   = 240;
    localparam int RANDOM_WRITES  = 1700;
    localparam int CALM_TAIL      = 250;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;

    // Register slots past the tint register, which the block must ignore
    localparam logic [ckb_pkg::REG_IDX_W-1:0] REG_SPARE     = 3'd5;
    localparam logic [ckb_pkg::REG_IDX_W-1:0] REG_LAST_SLOT = 3'd7;

    // One frame write as the block should present it
    typedef struct packed {
        logic [ckb_pkg::ADDR_W-1:0]  frame_address;
        logic [ckb_pkg::TEXEL_W-1:0] pixel;
        logic                        write_enable;
        logic                        last;
    } frame_write_t;

    // One row of the directed table: a register write or a texel request
    typedef struct packed {
        logic                          is_reg;
        logic [ckb_pkg::REG_IDX_W-1:0] idx;
        logic [31:0]                   data;
        logic                          known;
        frame_write_t                  want;
    } step_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ckb_pkg::PADDR_W-1:0]   paddr;
    logic [ckb_pkg::PDATA_W-1:0]   pwdata;
    logic [ckb_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          texel_valid;
    logic                          texel_ready;
    logic [ckb_pkg::TEXEL_W-1:0]   texel;
    logic                          out_valid;
    logic                          out_ready;
    logic [ckb_pkg::ADDR_W-1:0]    frame_address;
    logic [ckb_pkg::TEXEL_W-1:0]   pixel;
    logic                          write_enable;
    logic                          last;

    // Predictor copy of the configuration and walk counters
    logic [ckb_pkg::DEST_W-1:0]    cfg_dest_x;
    logic [ckb_pkg::DEST_W-1:0]    cfg_dest_y;
    logic [ckb_pkg::SIZE_W-1:0]    cfg_sprite_w;
    logic [ckb_pkg::SIZE_W-1:0]    cfg_sprite_h;
    logic [ckb_pkg::TEXEL_W-1:0]   cfg_tint;
    int                            walk_col;
    int                            walk_row;

    frame_write_t         pending_writes[$];
    int                   items_done;
    int                   writes_checked;
    int                   ends_seen;
    int                   transparent_seen;
    int                   reg_writes;
    int                   phases;
    int                   errors;
    int                   idle_cycles;
    int                   send_gap_pct;
    int                   recv_gap_pct;
    bit                   hold_long;

    color_key_sprite_blitter #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .texel_valid   (texel_valid),
        .texel_ready   (texel_ready),
        .texel         (texel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_address (frame_address),
        .pixel         (pixel),
        .write_enable  (write_enable),
        .last          (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Clip the requested rectangle against the frame
    function automatic void clip_rect(output int x0, output int y0, output int cw, output int ch);
        int x1;
        int y1;
        x0 = $signed(cfg_dest_x);
        y0 = $signed(cfg_dest_y);
        if (x0 > FRAME_WIDTH) x0 = FRAME_WIDTH;
        if (x0 < 0) x0 = 0;
        if (y0 > FRAME_HEIGHT) y0 = FRAME_HEIGHT;
        if (y0 < 0) y0 = 0;
        x1 = x0 + int'(cfg_sprite_w);
        y1 = y0 + int'(cfg_sprite_h);
        if (x1 > FRAME_WIDTH) x1 = FRAME_WIDTH;
        if (y1 > FRAME_HEIGHT) y1 = FRAME_HEIGHT;
        cw = x1 - x0;
        ch = y1 - y0;
    endfunction

    // Work out the frame write for one texel and advance the walk; 0 when nothing is written
    function automatic bit blit_texel(input logic [ckb_pkg::TEXEL_W-1:0] v,
                                      output frame_write_t w);
        int x0;
        int y0;
        int cw;
        int ch;
        int a;
        clip_rect(x0, y0, cw, ch);
        if (cw == 0 || ch == 0) return 1'b0;
        if (walk_col >= cw || walk_row >= ch)
        begin
            walk_col = 0;
            walk_row = 0;
        end
        a = (x0 + walk_col) + (y0 + walk_row) * FRAME_WIDTH;
        w.frame_address = a[ckb_pkg::ADDR_W-1:0];
        w.pixel         = v & cfg_tint;
        w.write_enable  = (v != '0);
        w.last          = (walk_col == cw - 1) && (walk_row == ch - 1);
        if (walk_col + 1 < cw)
            walk_col++;
        else
        begin
            walk_col = 0;
            walk_row = (walk_row + 1 < ch) ? walk_row + 1 : 0;
        end
        return 1'b1;
    endfunction

    // Random texel, weighted towards the transparent key and single-bit patterns
    function automatic logic [ckb_pkg::TEXEL_W-1:0] pick_texel();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            3:       return 32'd1 << $urandom_range(0, 31);
            4:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Now and then fill the bits above a register's width with noise
    function automatic logic [31:0] pad_word(input logic [31:0] val, input int bits);
        logic [31:0] keep;
        keep = (32'd1 << bits) - 32'd1;
        if ($urandom_range(0, 3) == 0) return (val & keep) | ($urandom & ~keep);
        return val;
    endfunction

    function automatic step_t reg_row(input logic [ckb_pkg::REG_IDX_W-1:0] idx,
                                      input logic [31:0] data);
        step_t s;
        s        = '0;
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic step_t tex_row(input logic [ckb_pkg::TEXEL_W-1:0] v);
        step_t s;
        s      = '0;
        s.data = v;
        return s;
    endfunction

    function automatic step_t tex_known(input logic [ckb_pkg::TEXEL_W-1:0] v, input int addr,
                                        input logic [ckb_pkg::TEXEL_W-1:0] pix, input bit we,
                                        input bit lst);
        step_t s;
        s                    = '0;
        s.data               = v;
        s.known              = 1'b1;
        s.want.frame_address = addr[ckb_pkg::ADDR_W-1:0];
        s.want.pixel         = pix;
        s.want.write_enable  = we;
        s.want.last          = lst;
        return s;
    endfunction

    // APB write: setup, access, then idle; update the predictor at the write edge
    task automatic write_reg(input logic [ckb_pkg::REG_IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            ckb_pkg::REG_DEST_X:   cfg_dest_x   = data[ckb_pkg::DEST_W-1:0];
            ckb_pkg::REG_DEST_Y:   cfg_dest_y   = data[ckb_pkg::DEST_W-1:0];
            ckb_pkg::REG_SPRITE_W: cfg_sprite_w = data[ckb_pkg::SIZE_W-1:0];
            ckb_pkg::REG_SPRITE_H: cfg_sprite_h = data[ckb_pkg::SIZE_W-1:0];
            ckb_pkg::REG_TINT:     cfg_tint     = data;
            default:      ;
        endcase
        // Geometry writes restart the walk at the top-left corner
        if (idx == ckb_pkg::REG_DEST_X || idx == ckb_pkg::REG_DEST_Y ||
            idx == ckb_pkg::REG_SPRITE_W || idx == ckb_pkg::REG_SPRITE_H)
        begin
            walk_col = 0;
            walk_row = 0;
        end
        @(posedge clk);
    endtask

    // Offer one texel request, with an optional gap before it; predict on acceptance
    task automatic send_texel(input logic [ckb_pkg::TEXEL_W-1:0] v, input bit known,
                              input frame_write_t want);
        frame_write_t w;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            texel_valid <= 1'b0;
            texel       <= $urandom;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        texel_valid <= 1'b1;
        texel       <= v;
        do @(posedge clk); while (!texel_ready);
        if (blit_texel(v, w))
        begin
            pending_writes.push_back(known ? want : w);
            items_done++;
        end
    endtask

    // Drop the request line and wait until every predicted write has come back
    task automatic wait_quiet();
        texel_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: random ready bursts, one long hold on request
    initial
    begin : receiver
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (hold_long)
            begin
                hold_long = 1'b0;
                hold      = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct)
            begin
                hold      = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest predicted write
    always @(posedge clk)
    begin : check_writes
        frame_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: addr %0d pixel %h we %b last %b",
                             frame_address, pixel, write_enable, last);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (frame_address !== want.frame_address || pixel !== want.pixel ||
                    write_enable !== want.write_enable || last !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch on write %0d: expected addr %0d pixel %h we %b last %b",
                                 writes_checked, want.frame_address, want.pixel,
                                 want.write_enable, want.last);
                        $display("    got addr %0d pixel %h we %b last %b",
                                 frame_address, pixel, write_enable, last);
                    end
                end
                writes_checked++;
                if (want.last) ends_seen++;
                if (!want.write_enable) transparent_seen++;
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no request moving anywhere
    always @(posedge clk)
    begin
        if ((texel_valid && texel_ready) || (out_valid && out_ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d writes outstanding",
                     WATCHDOG_LIMIT, pending_writes.size());
            $display("color_key_sprite_blitter_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        step_t        script[$];
        frame_write_t none;
        int           start;
        int           dx;
        int           dy;
        int           sw;
        int           sh;
        int           n;
        int           x0;
        int           y0;
        int           cw;
        int           ch;
        bit           hold_done;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        texel_valid  = 1'b0;
        texel        = '0;
        hold_long    = 1'b0;
        send_gap_pct = 20;
        recv_gap_pct = 20;
        idle_cycles  = 0;
        errors       = 0;
        items_done   = 0;
        hold_done    = 1'b0;
        none         = '0;
        cfg_dest_x   = '0;
        cfg_dest_y   = '0;
        cfg_sprite_w = '0;
        cfg_sprite_h = '0;
        cfg_tint     = ckb_pkg::TINT_RESET;
        walk_col     = 0;
        walk_row     = 0;

        // Empty rectangle after reset: texel dropped
        script.push_back(tex_row(32'hDEAD_BEEF));
        // 2x2 at the origin, walk once round and wrap
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_W, 32'd2));
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_H, 32'd2));
        script.push_back(tex_known(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 0));
        script.push_back(tex_known(32'h0000_0000, 1, 32'h0000_0000, 0, 0));
        script.push_back(tex_known(32'h0000_0001, 320, 32'h0000_0001, 1, 0));
        script.push_back(tex_known(32'h8000_0000, 321, 32'h8000_0000, 1, 1));
        script.push_back(tex_known(32'hAAAA_AAAA, 0, 32'hAAAA_AAAA, 1, 0));
        // Zero tint keeps the walk going and still writes
        script.push_back(reg_row(ckb_pkg::REG_TINT, 32'h0000_0000));
        script.push_back(tex_known(32'hFFFF_FFFF, 1, 32'h0000_0000, 1, 0));
        // Unused register slot changes nothing
        script.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
        script.push_back(tex_known(32'h5555_5555, 320, 32'h0000_0000, 1, 0));
        // Negative origin clamps to the corner
        script.push_back(reg_row(ckb_pkg::REG_TINT, 32'h0F0F_0F0F));
        script.push_back(reg_row(ckb_pkg::REG_DEST_X, 32'hFFFF_F000));
        script.push_back(reg_row(ckb_pkg::REG_DEST_Y, 32'hFFFF_FFFF));
        script.push_back(tex_known(32'hFFFF_FFFF, 0, 32'h0F0F_0F0F, 1, 0));
        // Origin past the right edge: empty
        script.push_back(reg_row(ckb_pkg::REG_DEST_X, 32'd4095));
        script.push_back(tex_row(32'h1234_5678));
        // Largest size at the bottom-right pixel: every texel is the last
        script.push_back(reg_row(ckb_pkg::REG_DEST_X, 32'd319));
        script.push_back(reg_row(ckb_pkg::REG_DEST_Y, 32'd239));
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_W, 32'd4095));
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_H, 32'd4095));
        script.push_back(tex_known(32'hFFFF_FFFF, 76799, 32'h0F0F_0F0F, 1, 1));
        script.push_back(tex_known(32'h0000_0000, 76799, 32'h0000_0000, 0, 1));
        // Origin past the bottom edge: empty
        script.push_back(reg_row(ckb_pkg::REG_DEST_Y, 32'd4095));
        script.push_back(tex_row(32'hCAFE_F00D));
        // Clipped 3x2 in the bottom-right corner
        script.push_back(reg_row(ckb_pkg::REG_TINT, 32'hFFFF_FFFF));
        script.push_back(reg_row(ckb_pkg::REG_DEST_X, 32'd317));
        script.push_back(reg_row(ckb_pkg::REG_DEST_Y, 32'd238));
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_W, 32'd5));
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_H, 32'd2));
        repeat (6) script.push_back(tex_row(pick_texel()));
        // Zero width: empty
        script.push_back(reg_row(ckb_pkg::REG_SPRITE_W, 32'd0));
        script.push_back(tex_row(32'h0000_FFFF));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                wait_quiet();
                write_reg(script[i].idx, script[i].data);
            end
            else
                send_texel(script[i].data, script[i].known, script[i].want);
        end

        // Random geometry phases
        start = items_done;
        while (items_done - start < RANDOM_WRITES)
        begin
            wait_quiet();
            phases++;
            if (items_done - start > RANDOM_WRITES - CALM_TAIL)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    send_gap_pct = 0;
                    2:       send_gap_pct = 5;
                    3:       send_gap_pct = 25;
                    default: send_gap_pct = 50;
                endcase
                case ($urandom_range(0, 4))
                    0, 1:    recv_gap_pct = 0;
                    2:       recv_gap_pct = 5;
                    3:       recv_gap_pct = 25;
                    default: recv_gap_pct = 50;
                endcase
            end

            // Pick a geometry: mostly small, some clipped at an edge, some huge or empty
            case ($urandom_range(0, 19))
                0:
                begin
                    dx = $urandom_range(0, FRAME_WIDTH - 1);
                    dy = $urandom_range(0, FRAME_HEIGHT - 1);
                    sw = $urandom_range(1, 16);
                    sh = $urandom_range(1, 6);
                    case ($urandom_range(0, 3))
                        0:       sw = 0;
                        1:       sh = 0;
                        2:       dx = $urandom_range(FRAME_WIDTH, 4095);
                        default: dy = $urandom_range(FRAME_HEIGHT, 4095);
                    endcase
                end
                1, 2:
                begin
                    dx = int'($urandom_range(0, 8191)) - 4096;
                    dy = int'($urandom_range(0, 8191)) - 4096;
                    sw = $urandom_range(0, 4095);
                    sh = $urandom_range(0, 4095);
                end
                3, 4, 5:
                begin
                    dx = $urandom_range(0, 1) ? int'($urandom_range(300, 330))
                                              : -int'($urandom_range(1, 40));
                    dy = $urandom_range(0, 1) ? int'($urandom_range(230, 250))
                                              : -int'($urandom_range(1, 10));
                    sw = $urandom_range(1, 40);
                    sh = $urandom_range(1, 8);
                end
                default:
                begin
                    dx = $urandom_range(0, FRAME_WIDTH - 1);
                    dy = $urandom_range(0, FRAME_HEIGHT - 1);
                    sw = $urandom_range(1, 16);
                    sh = $urandom_range(1, 6);
                end
            endcase

            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(ckb_pkg::REG_TINT, 32'hFFFF_FFFF);
                    1:       write_reg(ckb_pkg::REG_TINT, 32'h0000_0000);
                    default: write_reg(ckb_pkg::REG_TINT, $urandom);
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(ckb_pkg::REG_IDX_W'(REG_SPARE
                          + $urandom_range(0, REG_LAST_SLOT - REG_SPARE)), $urandom);
            write_reg(ckb_pkg::REG_DEST_X, pad_word(dx, ckb_pkg::DEST_W));
            write_reg(ckb_pkg::REG_DEST_Y, pad_word(dy, ckb_pkg::DEST_W));
            write_reg(ckb_pkg::REG_SPRITE_W, pad_word(sw, ckb_pkg::SIZE_W));
            write_reg(ckb_pkg::REG_SPRITE_H, pad_word(sh, ckb_pkg::SIZE_W));

            // Mostly whole rectangles, sometimes cut short
            clip_rect(x0, y0, cw, ch);
            if (cw * ch == 0)
                n = $urandom_range(2, 6);
            else if (cw * ch <= 64 && $urandom_range(0, 9) < 7)
                n = cw * ch * $urandom_range(1, 3);
            else
                n = $urandom_range(1, (cw * ch < 60) ? cw * ch : 60);

            // Once: stall the receiver for a long stretch while requests keep coming
            if (!hold_done && cw * ch != 0 && items_done - start > 300)
            begin
                hold_done = 1'b1;
                hold_long = 1'b1;
                if (n < 16) n = 16;
            end

            repeat (n) send_texel(pick_texel(), 1'b0, none);
        end

        wait_quiet();
        if (pending_writes.size() != 0)
        begin
            errors++;
            $display("%0d predicted writes never arrived", pending_writes.size());
        end

        $display("covered %0d frame writes over %0d geometry phases",
                 writes_checked, phases);
        $display("%0d rectangle ends, %0d transparent, %0d register writes, %0d mismatches",
                 ends_seen, transparent_seen, reg_writes, errors);
        if (errors == 0)
            $display("color_key_sprite_blitter_tb: done, clean");
        else
            $display("color_key_sprite_blitter_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/ckb_pkg.sv
sv/ckb_regs.sv
sv/color_key_sprite_blitter.sv
sv/ckb_checker.sv
sim/color_key_sprite_blitter_tb.sv
